[hdl/pcbp_pkg.sv]
// ----------------------------------------------------------------------------
// pcbp_pkg
// Shared types and constants of the prefix code bit packer: request modes,
// controller states and the command and status bundles between controller
// and datapath.
// ----------------------------------------------------------------------------
package pcbp_pkg;

   localparam int SYMBOLS_DEF      = 256;
   localparam int MAX_CODE_LEN_DEF = 32;

   localparam int BYTE_W  = 8;             // output byte
   localparam int IDX_W   = 8;             // entry_index and symbol fields
   localparam int LEN_W   = 6;             // code_length field
   localparam int CODE_W  = 32;            // code_bits field
   localparam int MODE_W  = 2;
   localparam int ACC_W   = BYTE_W + CODE_W;
   localparam int CNT_W   = 6;             // holds 0..ACC_W
   localparam int ADDR_LIM_W = 17;         // wide enough to hold SYMBOLS itself

   // request tdata layout, lowest bit first
   localparam int IDX_LSB   = 0;
   localparam int LEN_LSB   = IDX_LSB + IDX_W;
   localparam int CODE_LSB  = LEN_LSB + LEN_W;
   localparam int SYM_LSB   = CODE_LSB + CODE_W;
   localparam int REQ_DATA_W = ((SYM_LSB + IDX_W + 7) / 8) * 8;

   typedef enum logic [MODE_W-1:0] {
      MODE_LOAD   = 2'd0,
      MODE_ENCODE = 2'd1,
      MODE_FLUSH  = 2'd2
   } mode_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_MERGE,
      ST_EMIT,
      ST_FLUSH
   } state_type;

   typedef struct packed {
      logic ram_wr;    // write table entry
      logic ram_rd;    // look up symbol
      logic merge;     // append looked-up code to pending bits
      logic emit;      // send the low byte of the accumulator
      logic flush;     // send the padded pending byte and clear
   } cmd_type;

   typedef struct packed {
      logic idx_ok;    // entry_index inside the table
      logic sym_ok;    // symbol inside the table
      logic need_emit; // merged word holds more than one byte
      logic last_emit; // byte being emitted is the final one
      logic out_free;  // output register can take a byte
   } stat_type;

endpackage

[hdl/pcbp_ram.sv]
// ----------------------------------------------------------------------------
// pcbp_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module pcbp_ram #(
   parameter  int WIDTH  = 8,
   parameter  int DEPTH  = 16,
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

[hdl/pcbp_ctrl.sv]
// ----------------------------------------------------------------------------
// pcbp_ctrl
// Controller of the bit packer: takes one request at a time and sequences
// table write, lookup, merge and byte emission in the datapath.
// ----------------------------------------------------------------------------
module pcbp_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_tvalid,
   output logic                req_tready,
   input  pcbp_pkg::mode_type  req_mode,
   input  pcbp_pkg::stat_type  stat,
   output pcbp_pkg::cmd_type   cmd
);

   pcbp_pkg::state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= pcbp_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in   = state_ff;
      cmd        = '0;
      req_tready = 1'b0;
      case (state_ff)
         pcbp_pkg::ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               case (req_mode)
                  pcbp_pkg::MODE_LOAD: begin
                     cmd.ram_wr = stat.idx_ok;
                  end
                  pcbp_pkg::MODE_ENCODE: begin
                     cmd.ram_rd = stat.sym_ok;
                     if (stat.sym_ok) begin
                        state_in = pcbp_pkg::ST_MERGE;
                     end
                  end
                  pcbp_pkg::MODE_FLUSH: begin
                     state_in = pcbp_pkg::ST_FLUSH;
                  end
                  default: begin
                  end
               endcase
            end
         end
         pcbp_pkg::ST_MERGE: begin
            cmd.merge = 1'b1;
            state_in  = stat.need_emit ? pcbp_pkg::ST_EMIT : pcbp_pkg::ST_IDLE;
         end
         pcbp_pkg::ST_EMIT: begin
            if (stat.out_free) begin
               cmd.emit = 1'b1;
               if (stat.last_emit) begin
                  state_in = pcbp_pkg::ST_IDLE;
               end
            end
         end
         pcbp_pkg::ST_FLUSH: begin
            if (stat.out_free) begin
               cmd.flush = 1'b1;
               state_in  = pcbp_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = pcbp_pkg::ST_IDLE;
         end
      endcase
   end

endmodule

[hdl/pcbp_dp.sv]
// ----------------------------------------------------------------------------
// pcbp_dp
// Datapath of the bit packer: codeword table, bit accumulator with its fill
// count, and the output byte register.
// ----------------------------------------------------------------------------
module pcbp_dp #(
   parameter int SYMBOLS      = pcbp_pkg::SYMBOLS_DEF,
   parameter int MAX_CODE_LEN = pcbp_pkg::MAX_CODE_LEN_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  pcbp_pkg::cmd_type             cmd,
   output pcbp_pkg::stat_type            stat,
   input  logic [pcbp_pkg::IDX_W-1:0]    entry_index,
   input  logic [pcbp_pkg::LEN_W-1:0]    code_length,
   input  logic [pcbp_pkg::CODE_W-1:0]   code_bits,
   input  logic [pcbp_pkg::IDX_W-1:0]    symbol,
   output logic                          rsp_tvalid,
   input  logic                          rsp_tready,
   output logic [pcbp_pkg::BYTE_W-1:0]   rsp_tdata,
   output logic                          rsp_tlast
);

   localparam int ADDR_W  = (SYMBOLS > 1) ? $clog2(SYMBOLS) : 1;
   localparam int CAP     = (MAX_CODE_LEN < pcbp_pkg::CODE_W) ? MAX_CODE_LEN
                                                              : pcbp_pkg::CODE_W;
   localparam int ENTRY_W = pcbp_pkg::LEN_W + pcbp_pkg::CODE_W;
   localparam int LIM_W   = pcbp_pkg::ADDR_LIM_W;
   localparam int EXT_W   = LIM_W - 1;

   logic [EXT_W-1:0]                 idx_ext, sym_ext;
   logic [pcbp_pkg::LEN_W-1:0]       wr_len, rd_len;
   logic [pcbp_pkg::CODE_W-1:0]      rd_bits, rd_mask;
   logic [ENTRY_W-1:0]               rd_data;
   logic [pcbp_pkg::CNT_W-1:0]       cnt_sum;
   logic [pcbp_pkg::ACC_W-1:0]       acc_ff, acc_in;
   logic [pcbp_pkg::CNT_W-1:0]       cnt_ff, cnt_in;
   logic                             out_vld_ff, out_vld_in;
   logic [pcbp_pkg::BYTE_W-1:0]      out_byte_ff, out_byte_in;
   logic                             out_last_ff, out_last_in;

   assign idx_ext = EXT_W'(entry_index);
   assign sym_ext = EXT_W'(symbol);

   assign stat.idx_ok = {1'b0, idx_ext} < LIM_W'(SYMBOLS);
   assign stat.sym_ok = {1'b0, sym_ext} < LIM_W'(SYMBOLS);

   assign wr_len = (code_length > pcbp_pkg::LEN_W'(CAP)) ? pcbp_pkg::LEN_W'(CAP)
                                                         : code_length;

   pcbp_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (SYMBOLS)
   ) u_table (
      .clock   (clock),
      .wr_en   (cmd.ram_wr),
      .wr_addr (idx_ext[ADDR_W-1:0]),
      .wr_data ({wr_len, code_bits}),
      .rd_en   (cmd.ram_rd),
      .rd_addr (sym_ext[ADDR_W-1:0]),
      .rd_data (rd_data)
   );

   assign rd_len  = rd_data[ENTRY_W-1 -: pcbp_pkg::LEN_W];
   assign rd_bits = rd_data[pcbp_pkg::CODE_W-1:0];

   // table bits beyond the code length must not reach the stream
   always_comb begin
      for (int i = 0; i < pcbp_pkg::CODE_W; i++) begin
         rd_mask[i] = pcbp_pkg::LEN_W'(i) < rd_len;
      end
   end

   assign cnt_sum = cnt_ff + rd_len;

   // a full byte leaves only once another bit is behind it
   assign stat.need_emit = cnt_sum > pcbp_pkg::CNT_W'(pcbp_pkg::BYTE_W);
   assign stat.last_emit = cnt_ff <= pcbp_pkg::CNT_W'(2 * pcbp_pkg::BYTE_W);
   assign stat.out_free  = !out_vld_ff || rsp_tready;

   always_comb begin
      acc_in = acc_ff;
      cnt_in = cnt_ff;
      if (cmd.merge) begin
         // pending count is at most one byte here
         acc_in = acc_ff | (pcbp_pkg::ACC_W'(rd_bits & rd_mask) << cnt_ff[3:0]);
         cnt_in = cnt_sum;
      end else if (cmd.emit) begin
         acc_in = acc_ff >> pcbp_pkg::BYTE_W;
         cnt_in = cnt_ff - pcbp_pkg::CNT_W'(pcbp_pkg::BYTE_W);
      end else if (cmd.flush) begin
         acc_in = '0;
         cnt_in = '0;
      end
   end

   always_comb begin
      out_byte_in = out_byte_ff;
      out_last_in = out_last_ff;
      out_vld_in  = out_vld_ff && !rsp_tready;
      if (cmd.emit || cmd.flush) begin
         out_byte_in = acc_ff[pcbp_pkg::BYTE_W-1:0];
         out_last_in = cmd.flush || stat.last_emit;
         out_vld_in  = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         acc_ff     <= '0;
         cnt_ff     <= '0;
         out_vld_ff <= 1'b0;
      end else begin
         acc_ff     <= acc_in;
         cnt_ff     <= cnt_in;
         out_vld_ff <= out_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      out_byte_ff <= out_byte_in;
      out_last_ff <= out_last_in;
   end

   assign rsp_tvalid = out_vld_ff;
   assign rsp_tdata  = out_byte_ff;
   assign rsp_tlast  = out_last_ff;

endmodule

[hdl/prefix_code_bit_packer_core.sv]
// Prefix code bit packer. A load request (tuser 0) writes one codeword table
// entry; lengths above the maximum are clamped. An encode request (tuser 1)
// reads the table, merges the code into the pending bits and then sends 0 to
// 4 bytes, one per cycle through the single output register while the output
// side does not stall. A flush request (tuser 2) sends the zero-padded
// pending byte, even an empty one. Bits fill each byte from its LSB, and a
// full byte is held until the next bit arrives. tlast marks the final byte of
// each request. The table is not cleared at reset: encoding a symbol that was
// never loaded gives undefined bytes.
// ----------------------------------------------------------------------------
// prefix_code_bit_packer_core
// Top level: stream ports, controller and datapath.
// ----------------------------------------------------------------------------
module prefix_code_bit_packer_core #(
   parameter int SYMBOLS      = pcbp_pkg::SYMBOLS_DEF,
   parameter int MAX_CODE_LEN = pcbp_pkg::MAX_CODE_LEN_DEF
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_tvalid,
   output logic                             req_tready,
   // entry_index[7:0], code_length[13:8], code_bits[45:14], symbol[53:46]
   input  logic [pcbp_pkg::REQ_DATA_W-1:0]  req_tdata,
   // mode[1:0]
   input  logic [pcbp_pkg::MODE_W-1:0]      req_tuser,
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   // out_byte[7:0]
   output logic [pcbp_pkg::BYTE_W-1:0]      rsp_tdata,
   output logic                             rsp_tlast
);

   pcbp_pkg::cmd_type  cmd;
   pcbp_pkg::stat_type stat;
   pcbp_pkg::mode_type req_mode;

   assign req_mode = pcbp_pkg::mode_type'(req_tuser);

   pcbp_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_mode   (req_mode),
      .stat       (stat),
      .cmd        (cmd)
   );

   pcbp_dp #(
      .SYMBOLS      (SYMBOLS),
      .MAX_CODE_LEN (MAX_CODE_LEN)
   ) u_dp (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .stat        (stat),
      .entry_index (req_tdata[pcbp_pkg::IDX_LSB +: pcbp_pkg::IDX_W]),
      .code_length (req_tdata[pcbp_pkg::LEN_LSB +: pcbp_pkg::LEN_W]),
      .code_bits   (req_tdata[pcbp_pkg::CODE_LSB +: pcbp_pkg::CODE_W]),
      .symbol      (req_tdata[pcbp_pkg::SYM_LSB +: pcbp_pkg::IDX_W]),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tlast   (rsp_tlast)
   );

`ifndef SYNTHESIS
   // a byte is only pushed when the output register can take it
   a_emit_free: assert property (@(posedge clock) disable iff (reset)
      (cmd.emit || cmd.flush) |-> stat.out_free)
      else $error("byte pushed into a full output register");

   a_emit_flush_excl: assert property (@(posedge clock) disable iff (reset)
      !(cmd.emit && cmd.flush))
      else $error("emit and flush in the same cycle");

   // accepted encode request merges its lookup in the following cycle
   a_encode_merge: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready && req_mode == pcbp_pkg::MODE_ENCODE && stat.sym_ok)
      |=> cmd.merge)
      else $error("encode request not merged after lookup");

   // no new request while the flush byte waits to enter the output register
   a_flush_busy: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready && req_mode == pcbp_pkg::MODE_FLUSH) |=> !req_tready)
      else $error("request accepted during flush");
`endif

endmodule
